### sv/kvtr_pkg.sv
package kvtr_pkg;

  // Control from the sequencer to the scan unit for one cycle.
  typedef struct packed {
    logic clear;      // start a new scan
    logic cmp_en;     // a read key is present this cycle
    logic entry_vld;  // valid bit of the slot being compared
  } scan_ctl_t;

  // Flags the scan unit has gathered so far.
  typedef struct packed {
    logic hit;         // a valid slot holds the reference key
    logic free_found;  // a free slot has been seen
  } scan_stat_t;

endpackage

### sv/kvtr_scan_unit.sv
module kvtr_scan_unit #(
  parameter int CAPACITY  = 16,
  parameter int KEY_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  kvtr_pkg::scan_ctl_t          ctl,
  input  logic [$clog2(CAPACITY)-1:0]  idx,
  input  logic [KEY_WIDTH-1:0]         rd_key,
  input  logic [KEY_WIDTH-1:0]         ref_key,
  output kvtr_pkg::scan_stat_t         stat,
  output logic [$clog2(CAPACITY)-1:0]  hit_idx,
  output logic [$clog2(CAPACITY)-1:0]  free_idx,
  output logic [$clog2(CAPACITY+1)-1:0] smaller
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic             key_eq;
  logic             key_lt;
  logic             hit_r;
  logic             free_r;
  logic [IDX_W-1:0] hit_idx_r;
  logic [IDX_W-1:0] free_idx_r;
  logic [CNT_W-1:0] smaller_r;

  // The comparators of the block: equality for key match, less-than for rank counting.
  assign key_eq = (rd_key == ref_key);
  assign key_lt = (rd_key < ref_key);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r     <= 1'b0;
      free_r    <= 1'b0;
      smaller_r <= '0;
    end else if (ctl.clear) begin
      hit_r     <= 1'b0;
      free_r    <= 1'b0;
      smaller_r <= '0;
    end else if (ctl.cmp_en) begin
      if (ctl.entry_vld) begin
        if (key_eq && !hit_r) begin
          hit_r     <= 1'b1;
          hit_idx_r <= idx;
        end
        if (key_lt) begin
          smaller_r <= smaller_r + CNT_W'(1);
        end
      end else if (!free_r) begin
        // Slots are scanned upward, so the first free one is the lowest.
        free_r     <= 1'b1;
        free_idx_r <= idx;
      end
    end
  end

  assign stat.hit        = hit_r;
  assign stat.free_found = free_r;
  assign hit_idx         = hit_idx_r;
  assign free_idx        = free_idx_r;
  assign smaller         = smaller_r;

endmodule

### sv/key_value_table_with_rank_unit.sv
// Bounded table of unique key/value pairs with insert, update, insert-or-update,
// erase, lookup and get-by-rank requests. A request is taken when start is high
// and busy is low; its single result appears on the out_ ports for exactly one
// cycle with out_valid high and must be captured then, since the receiver
// cannot stall the block. Each request walks the key memory through its one
// read port, one slot a cycle, into the comparators of the scan unit: insert,
// update, insert-or-update, erase and lookup go from the scan through a drain
// step to the execute step, and a lookup that hits adds a value-output step
// after its value read. Get by rank tries candidate slots in turn, skips free
// ones and counts smaller keys with a full walk for each valid candidate, then
// reads the value of the one that matches. An out-of-range rank or an unused
// request code answers straight from idle without raising busy. busy drops in
// the cycle the result is shown.
module key_value_table_with_rank_unit #(
  parameter int CAPACITY    = 16,
  parameter int KEY_WIDTH   = 32,
  parameter int VALUE_WIDTH = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [2:0]                    in_req_type,
  input  logic [KEY_WIDTH-1:0]          in_search_key,
  input  logic [VALUE_WIDTH-1:0]        in_new_value,
  input  logic [$clog2(CAPACITY)-1:0]   in_rank_index,
  output logic                          out_valid,
  output logic                          out_ok,
  output logic [KEY_WIDTH-1:0]          out_found_key,
  output logic [VALUE_WIDTH-1:0]        out_found_value,
  output logic [$clog2(CAPACITY+1)-1:0] out_item_count,
  output logic                          out_table_full
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

  localparam logic [2:0] REQ_INSERT = 3'd0;
  localparam logic [2:0] REQ_UPDATE = 3'd1;
  localparam logic [2:0] REQ_UPSERT = 3'd2;
  localparam logic [2:0] REQ_ERASE  = 3'd3;
  localparam logic [2:0] REQ_LOOKUP = 3'd4;
  localparam logic [2:0] REQ_RANK   = 3'd5;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_EXEC  = 3'd3;
  localparam logic [2:0] S_VOUT  = 3'd4;
  localparam logic [2:0] S_RCAND = 3'd5;
  localparam logic [2:0] S_RLOAD = 3'd6;
  localparam logic [2:0] S_REND  = 3'd7;

  logic [2:0]             state_r;
  logic [2:0]             req_r;
  logic [KEY_WIDTH-1:0]   key_r;
  logic [VALUE_WIDTH-1:0] val_r;
  logic [IDX_W-1:0]       rank_r;
  logic [IDX_W-1:0]       scan_addr_r;
  logic                   cmp_vld_r;
  logic [IDX_W-1:0]       cmp_idx_r;
  logic [IDX_W-1:0]       cand_r;
  logic [KEY_WIDTH-1:0]   cand_key_r;
  logic [CAPACITY-1:0]    valid_r;
  logic [CNT_W-1:0]       count_r;

  logic                   out_valid_r;
  logic                   out_ok_r;
  logic [KEY_WIDTH-1:0]   out_key_r;
  logic [VALUE_WIDTH-1:0] out_val_r;
  logic [CNT_W-1:0]       out_count_r;
  logic                   out_full_r;

  logic [KEY_WIDTH-1:0]   key_mem [CAPACITY];
  logic [VALUE_WIDTH-1:0] val_mem [CAPACITY];
  logic [KEY_WIDTH-1:0]   key_q_r;
  logic [VALUE_WIDTH-1:0] val_q_r;

  logic                   key_re;
  logic [IDX_W-1:0]       key_ra;
  logic                   key_we;
  logic                   val_re;
  logic [IDX_W-1:0]       val_ra;
  logic                   val_we;
  logic [IDX_W-1:0]       val_wa;

  kvtr_pkg::scan_ctl_t    scan_ctl;
  kvtr_pkg::scan_stat_t   scan_stat;
  logic [IDX_W-1:0]       hit_idx;
  logic [IDX_W-1:0]       free_idx;
  logic [CNT_W-1:0]       smaller;
  logic [KEY_WIDTH-1:0]   ref_key;
  logic                   is_ins;
  logic                   do_add;

  assign busy = (state_r != S_IDLE);

  assign is_ins  = (req_r == REQ_INSERT) || (req_r == REQ_UPSERT);
  assign do_add  = is_ins && !scan_stat.hit && scan_stat.free_found;
  assign ref_key = (req_r == REQ_RANK) ? cand_key_r : key_r;

  assign scan_ctl.clear     = (start && !busy) || (state_r == S_RLOAD);
  assign scan_ctl.cmp_en    = cmp_vld_r;
  assign scan_ctl.entry_vld = valid_r[cmp_idx_r];

  kvtr_scan_unit #(
    .CAPACITY  (CAPACITY),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (scan_ctl),
    .idx      (cmp_idx_r),
    .rd_key   (key_q_r),
    .ref_key  (ref_key),
    .stat     (scan_stat),
    .hit_idx  (hit_idx),
    .free_idx (free_idx),
    .smaller  (smaller)
  );

  // Memory port control.
  always_comb begin
    key_re = (state_r == S_SCAN) || (state_r == S_RCAND);
    key_ra = (state_r == S_SCAN) ? scan_addr_r : cand_r;
    key_we = (state_r == S_EXEC) && do_add;
    val_re = (state_r == S_EXEC) || (state_r == S_REND);
    val_ra = (state_r == S_EXEC) ? hit_idx : cand_r;
    val_we = (state_r == S_EXEC) &&
             (do_add || (scan_stat.hit &&
                         ((req_r == REQ_UPSERT) || (req_r == REQ_UPDATE))));
    val_wa = scan_stat.hit ? hit_idx : free_idx;
  end

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[free_idx] <= key_r;
    end
    if (key_re) begin
      key_q_r <= key_mem[key_ra];
    end
    if (val_we) begin
      val_mem[val_wa] <= val_r;
    end
    if (val_re) begin
      val_q_r <= val_mem[val_ra];
    end
  end

  // Compare pipeline: the key read at one address is compared in the following cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_vld_r <= 1'b0;
    end else begin
      cmp_vld_r <= (state_r == S_SCAN);
    end
    cmp_idx_r <= scan_addr_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            req_r       <= in_req_type;
            key_r       <= in_search_key;
            val_r       <= in_new_value;
            rank_r      <= in_rank_index;
            scan_addr_r <= '0;
            cand_r      <= '0;
            if (in_req_type == REQ_RANK) begin
              if (CNT_W'(in_rank_index) < count_r) begin
                state_r <= S_RCAND;
              end else begin
                out_valid_r <= 1'b1;
                out_ok_r    <= 1'b0;
                out_key_r   <= '0;
                out_val_r   <= '0;
                out_count_r <= count_r;
                out_full_r  <= 1'b0;
              end
            end else if (in_req_type > REQ_RANK) begin
              out_valid_r <= 1'b1;
              out_ok_r    <= 1'b0;
              out_key_r   <= '0;
              out_val_r   <= '0;
              out_count_r <= count_r;
              out_full_r  <= 1'b0;
            end else begin
              state_r <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          scan_addr_r <= scan_addr_r + IDX_W'(1);
          if (scan_addr_r == LAST_IDX) begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state_r <= (req_r == REQ_RANK) ? S_REND : S_EXEC;
        end
        S_EXEC: begin
          out_key_r  <= '0;
          out_val_r  <= '0;
          out_full_r <= 1'b0;
          state_r    <= S_IDLE;
          unique case (req_r)
            REQ_INSERT, REQ_UPSERT: begin
              if (scan_stat.hit) begin
                out_ok_r    <= (req_r == REQ_UPSERT);
                out_count_r <= count_r;
              end else if (scan_stat.free_found) begin
                valid_r[free_idx] <= 1'b1;
                count_r     <= count_r + CNT_W'(1);
                out_ok_r    <= 1'b1;
                out_count_r <= count_r + CNT_W'(1);
              end else begin
                out_ok_r    <= 1'b0;
                out_full_r  <= 1'b1;
                out_count_r <= count_r;
              end
            end
            REQ_ERASE: begin
              out_ok_r <= scan_stat.hit;
              if (scan_stat.hit) begin
                valid_r[hit_idx] <= 1'b0;
                count_r     <= count_r - CNT_W'(1);
                out_count_r <= count_r - CNT_W'(1);
              end else begin
                out_count_r <= count_r;
              end
            end
            default: begin
              // Update and lookup leave the count as it is.
              out_ok_r    <= scan_stat.hit;
              out_count_r <= count_r;
            end
          endcase
          if ((req_r == REQ_LOOKUP) && scan_stat.hit) begin
            state_r <= S_VOUT;
          end else begin
            out_valid_r <= 1'b1;
          end
        end
        S_RCAND: begin
          if (valid_r[cand_r]) begin
            state_r <= S_RLOAD;
          end else if (cand_r == LAST_IDX) begin
            state_r     <= S_IDLE;
            out_valid_r <= 1'b1;
            out_ok_r    <= 1'b0;
            out_key_r   <= '0;
            out_val_r   <= '0;
            out_count_r <= count_r;
            out_full_r  <= 1'b0;
          end else begin
            cand_r <= cand_r + IDX_W'(1);
          end
        end
        S_RLOAD: begin
          cand_key_r  <= key_q_r;
          scan_addr_r <= '0;
          state_r     <= S_SCAN;
        end
        S_REND: begin
          if (smaller == CNT_W'(rank_r)) begin
            out_key_r <= cand_key_r;
            state_r   <= S_VOUT;
          end else if (cand_r == LAST_IDX) begin
            state_r     <= S_IDLE;
            out_valid_r <= 1'b1;
            out_ok_r    <= 1'b0;
            out_key_r   <= '0;
            out_val_r   <= '0;
            out_count_r <= count_r;
            out_full_r  <= 1'b0;
          end else begin
            cand_r  <= cand_r + IDX_W'(1);
            state_r <= S_RCAND;
          end
        end
        S_VOUT: begin
          // The value read issued in the previous state is now registered.
          state_r     <= S_IDLE;
          out_valid_r <= 1'b1;
          out_ok_r    <= 1'b1;
          out_val_r   <= val_q_r;
          out_count_r <= count_r;
          out_full_r  <= 1'b0;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_ok          = out_ok_r;
  assign out_found_key   = out_key_r;
  assign out_found_value = out_val_r;
  assign out_item_count  = out_count_r;
  assign out_table_full  = out_full_r;

endmodule
